// ===== src/assert_macros.svh =====
// Assertion helpers used by the RTL file ftp_reply_parser.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge once reset is released
`define FRP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define FRP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/frp_pkg.sv =====
package frp_pkg;

    // Input transaction kinds; code 3 carries no meaning and is dropped
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_TICK = 2'd1,
        KIND_ARM  = 2'd2
    } t_frp_kind;

    // Status classes of a result
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_MANY = 2'd1;
    localparam logic [1:0] ST_NOT_FND  = 2'd2;
    localparam logic [1:0] ST_BAD      = 2'd3;

    // Characters and codes
    localparam logic [7:0]  CH_NL    = 8'h0a;
    localparam logic [7:0]  CH_CR    = 8'h0d;
    localparam logic [7:0]  CH_NUL   = 8'h00;
    localparam logic [7:0]  CH_DASH  = 8'h2d;
    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [7:0]  CH_4     = 8'h34;
    localparam logic [7:0]  CH_5     = 8'h35;
    localparam logic [23:0] CODE_421 = 24'h343231;
    localparam logic [23:0] CODE_550 = 24'h353530;

    localparam logic [15:0] TIMEOUT_RST = 16'd60;

    // Line position saturates here: only the first four characters matter
    localparam logic [2:0] POS_SAT = 3'd4;

    typedef struct packed {
        t_frp_kind   kind;
        logic [7:0]  data_byte;
    } t_frp_in;

    typedef struct packed {
        logic [23:0] reply_code;
        logic [1:0]  status;
        logic        timed_out;
    } t_frp_out;

    // Status class of a finished reply code
    function automatic logic [1:0] frp_classify(input logic [23:0] code);
        logic [1:0] st;
        if (code[23:16] != CH_4 && code[23:16] != CH_5) begin
            st = ST_OK;
        end else if (code == CODE_421) begin
            st = ST_TOO_MANY;
        end else if (code == CODE_550) begin
            st = ST_NOT_FND;
        end else begin
            st = ST_BAD;
        end
        return st;
    endfunction

endpackage

// ===== src/ftp_reply_parser.sv =====
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+--------------------------------------------
// input    | in        | i_in_valid / o_in_ready   | i_in_data  (kind, data_byte)
// result   | out       | o_out_valid / i_out_ready | o_out_data (reply_code, status, timed_out)
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (timeout_ticks)
//
// One transaction per cycle while the result channel does not stall; a transaction is held
// in the input register, and its result is then loaded into the result register.
// Reset is synchronous, active low; it clears the parser state, disarms the timer
// and loads timeout_ticks with 60.
// A stalled result holds the result register and blocks only a transaction with a result.
// The config port is always ready and takes one write per cycle.
`include "assert_macros.svh"

module ftp_reply_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  frp_pkg::t_frp_in   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output frp_pkg::t_frp_out  o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);
    import frp_pkg::*;

    // Input register
    logic        r_in_valid;
    t_frp_in     r_in;

    // Result register
    logic        r_out_valid;
    t_frp_out    r_out;

    // Parser and timer state
    logic [15:0] r_timeout;
    logic [23:0] r_code, n_code;
    logic        r_code_known, n_code_known;
    logic [2:0]  r_line_pos, n_line_pos;
    logic        r_prefix_ok, n_prefix_ok;
    logic        r_line_decided, n_line_decided;
    logic        r_armed, n_armed;
    logic [15:0] r_idle, n_idle;

    logic        w_has_result;
    t_frp_out    w_result;
    logic        w_advance;
    logic [15:0] w_idle_inc;
    logic [7:0]  w_code_char;
    logic        w_ends;

    // Handshakes
    assign w_advance   = r_in_valid && (!w_has_result || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_idle_inc = r_idle + 16'd1;

    // Code character at the current line position
    always_comb begin
        case (r_line_pos)
            3'd0:    w_code_char = r_code[23:16];
            3'd1:    w_code_char = r_code[15:8];
            default: w_code_char = r_code[7:0];
        endcase
    end

    // Next state of parser and timer for the transaction in the input register
    always_comb begin
        n_code         = r_code;
        n_code_known   = r_code_known;
        n_line_pos     = r_line_pos;
        n_prefix_ok    = r_prefix_ok;
        n_line_decided = r_line_decided;
        n_armed        = r_armed;
        n_idle         = r_idle;
        w_has_result   = 1'b0;
        w_result       = '0;
        w_ends         = 1'b0;
        if (r_in_valid) begin
            case (r_in.kind)
                KIND_ARM: begin
                    n_armed = 1'b1;
                    n_idle  = '0;
                end
                KIND_TICK: begin
                    if (r_armed) begin
                        n_idle = w_idle_inc;
                        if (w_idle_inc >= r_timeout) begin
                            w_has_result        = 1'b1;
                            w_result.reply_code = '0;
                            w_result.status     = ST_BAD;
                            w_result.timed_out  = 1'b1;
                            n_code              = '0;
                            n_code_known        = 1'b0;
                            n_line_pos          = '0;
                            n_prefix_ok         = 1'b1;
                            n_line_decided      = 1'b0;
                            n_armed             = 1'b0;
                            n_idle              = '0;
                        end
                    end
                end
                KIND_BYTE: begin
                    n_idle = '0;
                    if (r_in.data_byte == CH_NL) begin
                        // End of line: decide whether the reply ends here
                        w_ends         = r_code_known ? r_line_decided : !r_line_decided;
                        n_code_known   = 1'b1;
                        n_line_pos     = '0;
                        n_prefix_ok    = 1'b1;
                        n_line_decided = 1'b0;
                        if (w_ends) begin
                            w_has_result        = 1'b1;
                            w_result.reply_code = r_code;
                            w_result.status     = frp_classify(r_code);
                            w_result.timed_out  = 1'b0;
                            n_code              = '0;
                            n_code_known        = 1'b0;
                            n_armed             = 1'b0;
                        end
                    end else if (r_in.data_byte != CH_CR && r_in.data_byte != CH_NUL) begin
                        // Code characters, then the separator character
                        if (r_line_pos < 3'd3) begin
                            if (!r_code_known) begin
                                case (r_line_pos)
                                    3'd0:    n_code[23:16] = r_code[23:16] | r_in.data_byte;
                                    3'd1:    n_code[15:8]  = r_code[15:8]  | r_in.data_byte;
                                    default: n_code[7:0]   = r_code[7:0]   | r_in.data_byte;
                                endcase
                            end else if (w_code_char != r_in.data_byte) begin
                                n_prefix_ok = 1'b0;
                            end
                        end else if (r_line_pos == 3'd3) begin
                            if (!r_code_known) begin
                                n_line_decided = (r_in.data_byte == CH_DASH);
                            end else begin
                                n_line_decided = r_prefix_ok && (r_in.data_byte == CH_SPACE);
                            end
                        end
                        if (r_line_pos < POS_SAT) begin
                            n_line_pos = r_line_pos + 3'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_timeout      <= TIMEOUT_RST;
            r_code         <= '0;
            r_code_known   <= 1'b0;
            r_line_pos     <= '0;
            r_prefix_ok    <= 1'b1;
            r_line_decided <= 1'b0;
            r_armed        <= 1'b0;
            r_idle         <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance && w_has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            if (w_advance) begin
                r_code         <= n_code;
                r_code_known   <= n_code_known;
                r_line_pos     <= n_line_pos;
                r_prefix_ok    <= n_prefix_ok;
                r_line_decided <= n_line_decided;
                r_armed        <= n_armed;
                r_idle         <= n_idle;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_advance && w_has_result) begin
            r_out <= w_result;
        end
    end

    // Checks
    `FRP_ASSERT(a_timeout_payload, i_clk, i_rst_n,
        (o_out_valid && o_out_data.timed_out) |->
            (o_out_data.reply_code == '0 && o_out_data.status == ST_BAD),
        "timeout result with nonzero code or wrong status")
    `FRP_ASSERT(a_disarm_on_result, i_clk, i_rst_n,
        (w_advance && w_has_result) |=> !r_armed,
        "timer still armed after a result")
    `FRP_ASSERT(a_decided_at_sat, i_clk, i_rst_n,
        r_line_decided |-> (r_line_pos == POS_SAT),
        "line decided before its fourth character")
    `FRP_ASSERT(a_ready_when_empty, i_clk, i_rst_n,
        !r_out_valid |-> o_in_ready,
        "input stalled while result register is empty")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import frp_pkg::*;

    // Kind code with no meaning; the block must drop it
    localparam logic [1:0] KIND_VOID = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int LONG_HOLD = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_frp_in     i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_frp_out    o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    // Predicted parser state
    logic [23:0] p_code = '0;
    logic        p_code_seen = 1'b0;
    logic [2:0]  p_col = '0;
    logic        p_same_prefix = 1'b1;
    logic        p_col4_set = 1'b0;
    logic        p_armed = 1'b0;
    logic [15:0] p_quiet = '0;
    logic [15:0] p_limit = TIMEOUT_RST;

    t_frp_in  pending_events[$];
    t_frp_out replies_due[$];
    t_frp_out want;

    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    int send_gap = 0;
    int take_gap = 0;
    int hold_left = 0;
    int n_queued = 0;
    int events_in = 0;
    int replies_out = 0;
    int timeouts_out = 0;
    int mismatches = 0;
    int settings_used = 0;
    int n_cycles = 0;

    ftp_reply_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Forget the reply in progress
    task automatic drop_reply();
        p_code = '0;
        p_code_seen = 1'b0;
        p_col = '0;
        p_same_prefix = 1'b1;
        p_col4_set = 1'b0;
    endtask

    // Advance the predicted parser by one input transaction
    task automatic track_parser(input t_frp_in ev);
        t_frp_out r;
        logic closes;
        int sh;
        r = '0;
        case (ev.kind)
            KIND_ARM: begin
                p_armed = 1'b1;
                p_quiet = '0;
            end
            KIND_TICK: begin
                if (p_armed) begin
                    p_quiet = p_quiet + 16'd1;
                    if (p_quiet >= p_limit) begin
                        r.status = ST_BAD;
                        r.timed_out = 1'b1;
                        replies_due.push_back(r);
                        drop_reply();
                        p_armed = 1'b0;
                        p_quiet = '0;
                    end
                end
            end
            KIND_BYTE: begin
                p_quiet = '0;
                if (ev.data_byte == CH_NL) begin
                    // first line ends the reply unless it had a dash
                    closes = p_code_seen ? p_col4_set : !p_col4_set;
                    p_code_seen = 1'b1;
                    p_col = '0;
                    p_same_prefix = 1'b1;
                    p_col4_set = 1'b0;
                    if (closes) begin
                        r.reply_code = p_code;
                        if (p_code[23:16] != CH_4 && p_code[23:16] != CH_5) begin
                            r.status = ST_OK;
                        end else if (p_code == CODE_421) begin
                            r.status = ST_TOO_MANY;
                        end else if (p_code == CODE_550) begin
                            r.status = ST_NOT_FND;
                        end else begin
                            r.status = ST_BAD;
                        end
                        replies_due.push_back(r);
                        drop_reply();
                        p_armed = 1'b0;
                    end
                end else if (ev.data_byte != CH_CR && ev.data_byte != CH_NUL) begin
                    sh = 16 - 8 * int'(p_col);
                    if (p_col < 3'd3) begin
                        if (!p_code_seen) begin
                            p_code[sh +: 8] = ev.data_byte;
                        end else if (p_code[sh +: 8] != ev.data_byte) begin
                            p_same_prefix = 1'b0;
                        end
                    end else if (p_col == 3'd3) begin
                        p_col4_set = p_code_seen ? (p_same_prefix && ev.data_byte == CH_SPACE)
                                                 : (ev.data_byte == CH_DASH);
                    end
                    if (p_col < POS_SAT) begin
                        p_col = p_col + 3'd1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Input driver: pops pending transactions, idles in random bursts when idle_on is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (idle_on && pending_events.size() != 0 && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 4);
                i_in_valid <= 1'b0;
            end else if (pending_events.size() != 0) begin
                i_in_data <= pending_events.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: predicts on input transactions, checks result transactions, drives ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                events_in++;
                track_parser(i_in_data);
            end
            if (o_out_valid && i_out_ready) begin
                replies_out++;
                if (o_out_data.timed_out) begin
                    timeouts_out++;
                end
                if (replies_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected no result, got code %h status %0d timed_out %0d",
                             $time, o_out_data.reply_code, o_out_data.status,
                             o_out_data.timed_out);
                end else begin
                    want = replies_due.pop_front();
                    if (o_out_data.reply_code !== want.reply_code) begin
                        mismatches++;
                        $display("%0t: reply_code expected %h, got %h",
                                 $time, want.reply_code, o_out_data.reply_code);
                    end
                    if (o_out_data.status !== want.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, o_out_data.status);
                    end
                    if (o_out_data.timed_out !== want.timed_out) begin
                        mismatches++;
                        $display("%0t: timed_out expected %0d, got %0d",
                                 $time, want.timed_out, o_out_data.timed_out);
                    end
                end
            end
            // ready: long hold on request, else random stall bursts while idle_on is set
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap--;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                take_gap = $urandom_range(0, 4);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] digit();
        return 8'($urandom_range(8'h30, 8'h39));
    endfunction

    task automatic put(input logic [1:0] k, input logic [7:0] b);
        pending_events.push_back(t_frp_in'({k, b}));
        if (k != KIND_VOID) begin
            n_queued++;
        end
    endtask

    task automatic put_line(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            put(KIND_BYTE, s[i]);
        end
        put(KIND_BYTE, CH_NL);
    endtask

    task automatic put_code(input logic [23:0] code, input int n);
        int i;
        for (i = 0; i < n; i++) begin
            put(KIND_BYTE, code[23 - 8 * i -: 8]);
        end
    endtask

    // Mostly printable text, now and then any byte
    task automatic put_text();
        int i, n;
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++) begin
            put(KIND_BYTE, $urandom_range(0, 15) == 0 ? 8'($urandom)
                                                      : 8'($urandom_range(8'h20, 8'h7e)));
        end
    endtask

    task automatic put_eol();
        case ($urandom_range(0, 3))
            0: begin
                put(KIND_BYTE, CH_CR);
                put(KIND_BYTE, CH_NL);
            end
            1: begin
                put(KIND_BYTE, CH_NUL);
                put(KIND_BYTE, CH_NL);
            end
            default: put(KIND_BYTE, CH_NL);
        endcase
    endtask

    task automatic put_ticks(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            put(KIND_TICK, 8'($urandom));
        end
    endtask

    // Tick runs aimed around the timeout when it is small
    task automatic maybe_ticks();
        int n;
        if ($urandom_range(0, 3) == 0) begin
            if (p_limit <= 16'd300) begin
                case ($urandom_range(0, 2))
                    0: n = int'(p_limit) - 1;
                    1: n = int'(p_limit);
                    default: n = $urandom_range(1, int'(p_limit) + 2);
                endcase
            end else begin
                n = $urandom_range(1, 20);
            end
            put_ticks(n);
        end
    endtask

    // One reply: single line, short, or multi-line with assorted middle lines
    task automatic queue_reply(input bit terse);
        logic [23:0] code;
        int shape, nmid, i;
        if ($urandom_range(0, 3) != 0) begin
            put(KIND_ARM, 8'($urandom));
        end
        case ($urandom_range(0, 7))
            0: code = CODE_421;
            1: code = CODE_550;
            2: code = {CH_4, digit(), digit()};
            3: code = {CH_5, digit(), digit()};
            4: code = {8'($urandom_range(8'h31, 8'h33)), digit(), digit()};
            5: code = {CH_4, 8'h32, digit()};
            6: code = {CH_5, CH_5, digit()};
            default: code = 24'($urandom);
        endcase
        shape = terse ? 0 : $urandom_range(0, 9);
        if (shape == 9) begin
            // short first line
            put_code(code, $urandom_range(0, 3));
            put_eol();
        end else if (shape >= 6) begin
            put_code(code, 3);
            put(KIND_BYTE, CH_DASH);
            put_text();
            put_eol();
            nmid = $urandom_range(0, 3);
            for (i = 0; i < nmid; i++) begin
                maybe_ticks();
                case ($urandom_range(0, 3))
                    0: put_text();
                    1: begin
                        put_code(code, 3);
                        put(KIND_BYTE, CH_DASH);
                        put_text();
                    end
                    2: begin
                        // one code character off by one bit
                        put_code(code ^ (24'h1 << (8 * $urandom_range(0, 2))), 3);
                        put(KIND_BYTE, CH_SPACE);
                    end
                    default: put_code(code, $urandom_range(0, 3));
                endcase
                put_eol();
            end
            // closing line, sometimes left out so the reply runs on
            if ($urandom_range(0, 7) != 0) begin
                maybe_ticks();
                put_code(code, 3);
                put(KIND_BYTE, CH_SPACE);
                put_text();
                put_eol();
            end
        end else begin
            put_code(code, 3);
            put(KIND_BYTE, $urandom_range(0, 5) == 0 ? 8'($urandom_range(8'h20, 8'h7e))
                                                     : CH_SPACE);
            if (!terse) begin
                put_text();
            end
            put_eol();
        end
        if (!terse) begin
            maybe_ticks();
        end
    endtask

    // Wait until everything is sent and answered, then let the pipeline drain
    task automatic settle();
        while (pending_events.size() != 0 || i_in_valid || replies_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] ticks);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= ticks;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        p_limit = ticks;
        settings_used++;
        @(negedge i_clk);
    endtask

    task automatic fill_random(input int budget, input bit idle);
        int stop_at, i, n;
        idle_on = idle;
        stop_at = n_queued + budget;
        while (n_queued < stop_at) begin
            if ($urandom_range(0, 7) == 0) begin
                // stray transactions of any kind
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++) begin
                    put(2'($urandom), 8'($urandom));
                end
            end else begin
                queue_reply(1'b0);
            end
        end
        settle();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: tick while disarmed, double arm, each status class
        put(KIND_TICK, 8'hFF);
        put(KIND_ARM, CH_NUL);
        put(KIND_ARM, CH_NUL);
        put_line("421");
        put_line("550-");
        put_line("551 ");
        put_line("550 x");
        put(KIND_BYTE, CH_CR);
        put_line("");
        put_line("4");
        repeat (3) put(KIND_BYTE, 8'hFF);
        put(KIND_BYTE, CH_NL);
        put(KIND_VOID, 8'hFF);
        put_line("220 ok");
        // timeout at the reset value; a re-arm restarts the count
        put(KIND_ARM, CH_NUL);
        put_ticks(int'(TIMEOUT_RST) - 1);
        put(KIND_ARM, CH_NUL);
        put_ticks(int'(TIMEOUT_RST));
        settle();

        write_timeout(16'd1);
        fill_random(250, 1'b1);

        write_timeout(16'hFFFF);
        put(KIND_ARM, CH_NUL);
        put_ticks(150);
        fill_random(250, 1'b1);

        // long output stall while short replies keep coming
        write_timeout(16'd2);
        hold_req = 1'b1;
        repeat (60) queue_reply(1'b1);
        settle();

        write_timeout(16'($urandom_range(3, 40)));
        fill_random(250, 1'b0);
        write_timeout(TIMEOUT_RST);
        fill_random(250, 1'b1);
        write_timeout(16'($urandom_range(1, 65535)));
        fill_random(250, 1'b1);
        write_timeout(16'($urandom_range(3, 12)));
        fill_random(250, 1'b0);

        $display("Covered %0d input transactions, %0d results (%0d timeouts), %0d mismatches",
                 events_in, replies_out, timeouts_out, mismatches);
        $display("Timeout settings: %0d writes from 1 up to 65535, plus one long output stall",
                 settings_used);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/frp_pkg.sv
src/ftp_reply_parser.sv
verif/tb_top.sv
